[rtl/wfs_pkg.sv]
package wfs_pkg;

  localparam int MAX_VARINT_BYTES_DEF = 10;
  localparam int COUNT_WIDTH_DEF      = 32;
  localparam int CFG_W                = 32;
  localparam int CFG_IDX_W            = 2;
  localparam int LEN_LIMIT_BITS       = 31;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;

  localparam logic [1:0] PART_TAG   = 2'd0;
  localparam logic [1:0] PART_LEN   = 2'd1;
  localparam logic [1:0] PART_VALUE = 2'd2;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam int FIXED64_BYTES = 8;
  localparam int FIXED32_BYTES = 4;

  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_BAD_OFFSET    = 4'd1;
  localparam logic [3:0] ERR_BAD_TAG       = 4'd2;
  localparam logic [3:0] ERR_BAD_VARINT    = 4'd3;
  localparam logic [3:0] ERR_FIXED64_SHORT = 4'd4;
  localparam logic [3:0] ERR_FIXED32_SHORT = 4'd5;
  localparam logic [3:0] ERR_BAD_LENGTH    = 4'd6;
  localparam logic [3:0] ERR_LEN_LIMIT     = 4'd7;
  localparam logic [3:0] ERR_LEN_WINDOW    = 4'd8;
  localparam logic [3:0] ERR_BAD_TYPE      = 4'd9;

  typedef struct packed {
    logic [CFG_W-1:0] buffer_length;
    logic [CFG_W-1:0] start_offset;
    logic [CFG_W-1:0] window_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [1:0] part;
    logic [2:0] wire_type;
    logic       field_last;
    logic       window_last;
    logic [3:0] error_code;
  } res_t;

endpackage

[rtl/wfs_chan_if.sv]
interface wfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface wfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [1:0] part;
  logic [2:0] wire_type;
  logic       field_last;
  logic       window_last;
  logic [3:0] error_code;

  modport source (output valid, output byte_out, output part, output wire_type,
                  output field_last, output window_last, output error_code,
                  input ready);
  modport sink (input valid, input byte_out, input part, input wire_type,
                input field_last, input window_last, input error_code,
                output ready);
endinterface

[rtl/wfs_core.sv]
module wfs_core import wfs_pkg::*; #(
  parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF,
  parameter int COUNT_WIDTH      = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [7:0] data_byte,
  output logic       res_v,
  output res_t       res
);

  localparam int CW    = COUNT_WIDTH;
  localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [5:0] {
    PH_SKIP    = 6'b000001,
    PH_TAG     = 6'b000010,
    PH_VALUE   = 6'b000100,
    PH_LEN     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  phase_t                    phase_r, phase_nxt;
  logic [CW-1:0]             pos_r, pos_nxt;
  logic [CW-1:0]             rw_r, rw_nxt;
  logic [CW-1:0]             pc_r, pc_nxt;
  logic [3:0]                vc_r, vc_nxt;
  logic [2:0]                wt_r, wt_nxt;
  logic [LEN_LIMIT_BITS-1:0] acc_r, acc_nxt;
  logic                      ovf_r, ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      pos_r   <= '0;
      rw_r    <= '0;
      pc_r    <= '0;
      vc_r    <= '0;
      wt_r    <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      rw_r    <= rw_nxt;
      pc_r    <= pc_nxt;
      vc_r    <= vc_nxt;
      wt_r    <= wt_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    logic             cont;
    logic             last;
    logic [CMP_W-1:0] win;
    logic [CMP_W-1:0] blen_x;
    logic [CMP_W-1:0] soff_x;
    logic [CMP_W-1:0] wlen_x;
    logic [CW-1:0]    pos_inc;
    logic [CW-1:0]    need;
    logic [6:0]       shamt;
    logic [63:0]      contrib;
    logic [1:0]       part;
    logic             fl;
    logic             wl;
    logic [3:0]       err;

    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    rw_nxt    = rw_r;
    pc_nxt    = pc_r;
    vc_nxt    = vc_r;
    wt_nxt    = wt_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    res_v     = 1'b0;
    cont      = data_byte[7];
    last      = 1'b0;
    blen_x    = CMP_W'(cfg.buffer_length);
    soff_x    = CMP_W'(cfg.start_offset);
    wlen_x    = CMP_W'(cfg.window_length);
    win       = '0;
    pos_inc   = pos_r + 1'b1;
    need      = '0;
    shamt     = '0;
    contrib   = '0;
    part      = PART_TAG;
    fl        = 1'b0;
    wl        = 1'b0;
    err       = ERR_NONE;

    if (step && (cfg.buffer_length != '0)) begin
      if (pos_r == '0) begin
        phase_nxt = PH_SKIP;
        vc_nxt    = '0;
        wt_nxt    = '0;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        pc_nxt    = '0;
        if (soff_x > blen_x) begin
          rw_nxt    = '0;
          res_v     = 1'b1;
          err       = ERR_BAD_OFFSET;
          phase_nxt = PH_DONE;
        end else begin
          win = blen_x - soff_x;
          if ((wlen_x != '0) && (wlen_x < win)) begin
            win = wlen_x;
          end
          rw_nxt = CW'(win);
          if (rw_nxt == '0) begin
            phase_nxt = PH_DONE;
          end
        end
      end

      if ((phase_nxt == PH_SKIP) && (CMP_W'(pos_r) == soff_x)) begin
        phase_nxt = PH_TAG;
        vc_nxt    = '0;
      end

      if ((phase_nxt == PH_TAG) || (phase_nxt == PH_VALUE) || (phase_nxt == PH_LEN) ||
          (phase_nxt == PH_PAYLOAD)) begin
        if (rw_nxt == '0) begin
          phase_nxt = PH_DONE;
        end else begin
          rw_nxt = rw_nxt - 1'b1;
          last   = (rw_nxt == '0);
          res_v  = 1'b1;
          case (phase_nxt)
            PH_TAG: begin
              part   = PART_TAG;
              vc_nxt = vc_nxt + 4'd1;
              if (vc_nxt == 4'd1) begin
                wt_nxt = data_byte[2:0];
              end
              if (cont) begin
                if ((vc_nxt >= 4'(MAX_VARINT_BYTES)) || last) begin
                  err = ERR_BAD_TAG;
                  wl  = last;
                end
              end else begin
                vc_nxt = '0;
                case (wt_nxt)
                  WT_VARINT: begin
                    if (last) begin
                      err = ERR_BAD_VARINT;
                      wl  = 1'b1;
                    end else begin
                      phase_nxt = PH_VALUE;
                    end
                  end
                  WT_FIXED64, WT_FIXED32: begin
                    need = (wt_nxt == WT_FIXED64) ? CW'(FIXED64_BYTES) : CW'(FIXED32_BYTES);
                    if (rw_nxt < need) begin
                      err = (wt_nxt == WT_FIXED64) ? ERR_FIXED64_SHORT : ERR_FIXED32_SHORT;
                      wl  = last;
                    end else begin
                      pc_nxt    = need;
                      phase_nxt = PH_PAYLOAD;
                    end
                  end
                  WT_LEN: begin
                    if (last) begin
                      err = ERR_BAD_LENGTH;
                      wl  = 1'b1;
                    end else begin
                      acc_nxt   = '0;
                      ovf_nxt   = 1'b0;
                      phase_nxt = PH_LEN;
                    end
                  end
                  default: begin
                    err = ERR_BAD_TYPE;
                    wl  = last;
                  end
                endcase
              end
            end
            PH_VALUE: begin
              part   = PART_VALUE;
              vc_nxt = vc_nxt + 4'd1;
              if (cont) begin
                if ((vc_nxt >= 4'(MAX_VARINT_BYTES)) || last) begin
                  err = ERR_BAD_VARINT;
                  wl  = last;
                end
              end else begin
                vc_nxt    = '0;
                phase_nxt = last ? PH_DONE : PH_TAG;
                fl        = 1'b1;
                wl        = last;
              end
            end
            PH_LEN: begin
              part    = PART_LEN;
              shamt   = 7'(vc_nxt) * 7'd7;
              contrib = 64'(data_byte[6:0]) << shamt;
              if (shamt < 7'd64) begin
                if (contrib[63:LEN_LIMIT_BITS] != '0) begin
                  ovf_nxt = 1'b1;
                end
                acc_nxt = acc_nxt | contrib[LEN_LIMIT_BITS-1:0];
              end
              vc_nxt = vc_nxt + 4'd1;
              if (cont) begin
                if ((vc_nxt >= 4'(MAX_VARINT_BYTES)) || last) begin
                  err = ERR_BAD_LENGTH;
                  wl  = last;
                end
              end else begin
                vc_nxt = '0;
                if (ovf_nxt) begin
                  err = ERR_LEN_LIMIT;
                  wl  = last;
                end else if (CMP_W'(acc_nxt) > CMP_W'(rw_nxt)) begin
                  err = ERR_LEN_WINDOW;
                  wl  = last;
                end else if (acc_nxt == '0) begin
                  phase_nxt = last ? PH_DONE : PH_TAG;
                  fl        = 1'b1;
                  wl        = last;
                end else begin
                  pc_nxt    = CW'(acc_nxt);
                  phase_nxt = PH_PAYLOAD;
                end
              end
            end
            PH_PAYLOAD: begin
              part   = PART_VALUE;
              pc_nxt = pc_nxt - 1'b1;
              wl     = last;
              if (pc_nxt == '0) begin
                phase_nxt = last ? PH_DONE : PH_TAG;
                fl        = 1'b1;
              end else if (last) begin
                phase_nxt = PH_DONE;
              end
            end
            default: begin
              res_v = 1'b0;
            end
          endcase
        end
      end

      if (res_v && (err != ERR_NONE)) begin
        phase_nxt = PH_DONE;
      end

      pos_nxt = pos_inc;
      if ((CMP_W'(pos_inc) >= blen_x) || (pos_inc == '0)) begin
        pos_nxt   = '0;
        phase_nxt = PH_SKIP;
      end
    end

    res = '{byte_out: data_byte, part: part, wire_type: wt_nxt, field_last: fl,
            window_last: wl, error_code: err};
  end

endmodule

[rtl/wire_field_splitter_unit.sv]
// Protobuf wire-format field splitter.
// in_ch carries the raw bytes of one buffer, one request per byte. out_ch
// carries one request per labeled byte of the split window: the byte, its
// part (tag, length prefix, value), the field's wire type, field and window
// end flags and an error code. Skipped bytes, bytes after the window and
// bytes after an error produce nothing; the block stays silent until the
// buffer ends, then the next byte starts a new buffer.
// The cfg port writes buffer_length, start_offset and window_length; write
// them only while no byte is in flight. They apply from the buffer's first
// byte on.
// The input register takes the byte, then the result register takes its
// label once the result register is free. Throughput: one byte per cycle
// while out_ch does not stall, set by the single-pass labeling step
// between the two registers.
// When out_ch stalls, the result register holds, the input register holds
// one more byte, and in_ch.ready drops once both are full.
// Reset clears the configuration to zero and the parser to the skip phase;
// no buffer is split until buffer_length is written nonzero.
module wire_field_splitter_unit import wfs_pkg::*; #(
  parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF,
  parameter int COUNT_WIDTH      = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  wfs_in_if.sink               in_ch,
  wfs_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t       cfg_r;
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       out_v_r;
  res_t       out_res_r;
  logic       advance;
  logic       in_ready;
  logic       core_res_v;
  res_t       core_res;

  assign advance  = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ready = !s1_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUFFER_LENGTH: cfg_r.buffer_length <= cfg_wdata;
        REG_START_OFFSET:  cfg_r.start_offset  <= cfg_wdata;
        REG_WINDOW_LENGTH: cfg_r.window_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.valid && in_ready) begin
      s1_v_r <= 1'b1;
    end else if (advance) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_byte_r <= in_ch.data_byte;
    end
  end

  wfs_core #(
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
    .COUNT_WIDTH      (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step      (advance),
    .data_byte (s1_byte_r),
    .res_v     (core_res_v),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= core_res_v;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_res_v) begin
      out_res_r <= core_res;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_v_r;
  assign out_ch.byte_out    = out_res_r.byte_out;
  assign out_ch.part        = out_res_r.part;
  assign out_ch.wire_type   = out_res_r.wire_type;
  assign out_ch.field_last  = out_res_r.field_last;
  assign out_ch.window_last = out_res_r.window_last;
  assign out_ch.error_code  = out_res_r.error_code;

  a_empty_buffer_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (cfg_r.buffer_length == '0)) |=> !out_v_r)
    else $error("result produced while buffer_length is zero");

  a_error_not_field_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_ch.error_code != ERR_NONE)) |-> !out_ch.field_last)
    else $error("error result marks a field end");

  a_tag_not_field_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ch.field_last) |-> (out_ch.part != PART_TAG))
    else $error("tag byte marked as field end");

  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !advance) |=> (s1_v_r && $stable(s1_byte_r)))
    else $error("pending byte dropped from input register");

endmodule
